// ----- hw/rtl/lfsp_pkg.sv -----
// Shared types, constants and helper functions for the line-follow steering PID core.
// It has no dependencies. The sequencer, the multiplier and the top level import it.
package lfsp_pkg;

  localparam int SENSOR_W = 8;
  localparam int SPEED_W  = 10;
  localparam int MODE_W   = 2;
  localparam int GAIN_W   = 8;
  localparam int LIMIT_W  = 15;
  localparam int DRIVE_W  = 13;
  localparam int ERR_W    = 5;
  localparam int INTEG_W  = 16;
  localparam int DIFF_W   = 6;
  localparam int ACC_W    = 30;
  localparam int MUL_W    = 18;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int X_W      = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1000;
  localparam logic [15:0] RECIP_5 = 16'd52429;
  localparam logic [X_W-1:0] X_CLAMP = 15'd20485;
  localparam logic [DRIVE_W-1:0] DRIVE_POS_MAX = 13'd4095;
  localparam logic [DRIVE_W-1:0] DRIVE_NEG_MAG = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CURVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SLOW  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IGAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DGAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ILIMIT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_SUM,
    ST_NUM_L, ST_ABS_L, ST_MUL_L, ST_NUM_R, ST_ABS_R, ST_MUL_R, ST_FIN
  } state_t;

  typedef enum logic [1:0] {MS_PROP, MS_INTEG, MS_DERIV, MS_RECIP} mul_sel_t;

  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     num_load;
    logic     num_right;
    logic     abs_load;
    logic     left_load;
    logic     out_load;
  } ctrl_t;

  function automatic logic signed [ERR_W-1:0] map_error(
    input logic [SENSOR_W-1:0] s,
    input logic [MODE_W-1:0] mode
  );
    logic curve;
    curve = (mode == MODE_CURVE);
    if (!s[3] && !s[4]) return 5'sd0;
    if (s[3] && !s[4]) return -5'sd1;
    if (!s[3] && s[4]) return 5'sd1;
    if (!s[4] && !s[5]) return -5'sd2;
    if (!s[2] && !s[3]) return 5'sd2;
    if (mode == MODE_SLOW) return 5'sd0;
    if (s[4] && !s[5]) return -5'sd3;
    if (!s[2] && s[3]) return 5'sd3;
    if (!s[5] && !s[6]) return -5'sd4;
    if (!s[1] && !s[2]) return 5'sd4;
    if (s[5] && !s[6]) return curve ? -5'sd6 : -5'sd5;
    if (!s[1] && s[2]) return curve ? 5'sd6 : 5'sd5;
    if (!s[6] && !s[7]) return curve ? -5'sd7 : -5'sd6;
    if (!s[0] && !s[1]) return curve ? 5'sd7 : 5'sd6;
    if (s[6] && !s[7]) return curve ? -5'sd9 : -5'sd7;
    if (!s[0] && s[1]) return curve ? 5'sd9 : 5'sd7;
    return 5'sd0;
  endfunction

  function automatic logic [DRIVE_W-1:0] sat_drive(
    input logic [DRIVE_W-1:0] q,
    input logic neg
  );
    if (neg) begin
      if (q > DRIVE_NEG_MAG) return DRIVE_NEG_MAG;
      return -q;
    end
    if (q > DRIVE_POS_MAX) return DRIVE_POS_MAX;
    return q;
  endfunction

endpackage

// ----- hw/rtl/lfsp_mult.sv -----
// Shared signed multiplier with a registered product for the steering core.
// It depends on lfsp_pkg for operand and product widths.
module lfsp_mult
  import lfsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ----- hw/rtl/lfsp_ctrl.sv -----
// Sequencer that steps the shared multiplier and accumulator through one word.
// It depends on lfsp_pkg for the state enum and the control struct.
module lfsp_ctrl
  import lfsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctrl           = '0;
    ctrl.mul_sel   = MS_PROP;
    ctrl.acc_op    = ACC_HOLD;
    unique case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (in_valid) state_next = ST_MUL_P;
      end
      ST_MUL_P: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_PROP;
        state_next   = ST_MUL_I;
      end
      ST_MUL_I: begin
        ctrl.acc_op  = ACC_LOAD;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_INTEG;
        state_next   = ST_MUL_D;
      end
      ST_MUL_D: begin
        ctrl.acc_op  = ACC_ADD;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_DERIV;
        state_next   = ST_SUM;
      end
      ST_SUM: begin
        ctrl.acc_op = ACC_ADD;
        state_next  = ST_NUM_L;
      end
      ST_NUM_L: begin
        ctrl.num_load = 1'b1;
        state_next    = ST_ABS_L;
      end
      ST_ABS_L: begin
        ctrl.abs_load = 1'b1;
        state_next    = ST_MUL_L;
      end
      ST_MUL_L: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_RECIP;
        state_next   = ST_NUM_R;
      end
      ST_NUM_R: begin
        ctrl.left_load = 1'b1;
        ctrl.num_load  = 1'b1;
        ctrl.num_right = 1'b1;
        state_next     = ST_ABS_R;
      end
      ST_ABS_R: begin
        ctrl.abs_load = 1'b1;
        state_next    = ST_MUL_R;
      end
      ST_MUL_R: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_RECIP;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/line_follow_steering_pid_core.sv -----
// Top level of the line-follow steering PID core: datapath, state and configuration.
// It depends on lfsp_pkg, lfsp_ctrl and lfsp_mult.
//
// Usage:
//   The slave stream (s_tvalid, s_tready, s_tdata, s_tuser) takes one word per
//   control step: the sensor vector and the base speed in s_tdata, the mode in
//   s_tuser. The master stream (m_tvalid, m_tready, m_tdata) returns one word
//   per input word with both wheel drives and the mapped line error.
//   The sequencer runs three products and two reciprocal divisions by 10240
//   through the one shared multiplier and takes a new word only once the last
//   word's result is loaded into the output register.
//   The result sits in an output register, so the next word is accepted while a
//   finished result still waits; if the receiver stalls longer, the sequencer
//   holds the second result in its last step and s_tready stays low.
//   The configuration port writes one register per cycle with cfg_we high; the
//   user must use it only while the core is idle, as the core does not enforce it.
//   Reset clears the stored error history, the gains to zero, the integral
//   limit to 1000 and drops any pending output word.
module line_follow_steering_pid_core
  import lfsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: line_sensors[7:0], base_speed[17:8], zero fill to 24 bits.
  input  logic [23:0]           s_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: left_drive[12:0], right_drive[25:13], line_error[30:26], zero.
  output logic [31:0]           m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_t ctrl;
  logic  out_free;
  logic  in_fire;

  logic [GAIN_W-1:0]  integral_gain;
  logic [GAIN_W-1:0]  derivative_gain;
  logic [LIMIT_W-1:0] integral_limit;

  logic signed [ERR_W-1:0]   previous_error;
  logic signed [INTEG_W-1:0] error_integral;

  logic [SPEED_W-1:0]        speed;
  logic [MODE_W-1:0]         mode;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W-1:0] sum;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   num;
  logic [X_W-1:0]            x;
  logic                      neg;
  logic [DRIVE_W-1:0]        left;

  logic signed [ERR_W-1:0]   err_in;
  logic signed [INTEG_W:0]   sum_raw;
  logic signed [INTEG_W:0]   sum_clamped;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_low;
  logic [DRIVE_W-1:0]        kp_speed;
  logic signed [ACC_W-1:0]   speed_scaled;
  logic [ACC_W-1:0]          mag;
  logic [ACC_W-12:0]         x_raw;
  logic [DRIVE_W-1:0]        q;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = ctrl.in_ready;

  lfsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  lfsp_mult u_mult (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_gain   <= '0;
      derivative_gain <= '0;
      integral_limit  <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IGAIN:  integral_gain   <= cfg_data[GAIN_W-1:0];
        REG_DGAIN:  derivative_gain <= cfg_data[GAIN_W-1:0];
        REG_ILIMIT: integral_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    err_in  = map_error(s_tdata[7:0], s_tuser);
    sum_raw = {error_integral[INTEG_W-1], error_integral}
            + {{(INTEG_W+1-ERR_W){err_in[ERR_W-1]}}, err_in};
    if (sum_raw >= $signed({2'b00, integral_limit})) begin
      sum_clamped = $signed({2'b00, integral_limit});
    end else if (sum_raw < -17'sd32768) begin
      sum_clamped = -17'sd32768;
    end else begin
      sum_clamped = sum_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_integral <= '0;
    end else if (in_fire) begin
      if (s_tuser == MODE_OFF) begin
        previous_error <= '0;
        error_integral <= '0;
      end else begin
        previous_error <= err_in;
        error_integral <= sum_clamped[INTEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      speed <= s_tdata[17:8];
      mode  <= s_tuser;
      if (s_tuser == MODE_OFF) begin
        err  <= '0;
        sum  <= '0;
        diff <= '0;
      end else begin
        err  <= err_in;
        sum  <= sum_clamped[INTEG_W-1:0];
        diff <= {err_in[ERR_W-1], err_in} - {previous_error[ERR_W-1], previous_error};
      end
    end
  end

  assign kp_speed = (mode == MODE_CURVE)
                  ? ({1'b0, speed, 2'b00} + {3'b000, speed})
                  : ({2'b00, speed, 1'b0} + {3'b000, speed});

  always_comb begin
    case (ctrl.mul_sel)
      MS_PROP: begin
        mul_a = {{(MUL_W-DRIVE_W){1'b0}}, kp_speed};
        mul_b = {{(MUL_W-ERR_W){err[ERR_W-1]}}, err};
      end
      MS_INTEG: begin
        mul_a = {{(MUL_W-GAIN_W){1'b0}}, integral_gain};
        mul_b = {{(MUL_W-INTEG_W){sum[INTEG_W-1]}}, sum};
      end
      MS_DERIV: begin
        mul_a = {{(MUL_W-GAIN_W){1'b0}}, derivative_gain};
        mul_b = {{(MUL_W-DIFF_W){diff[DIFF_W-1]}}, diff};
      end
      default: begin
        mul_a = {{(MUL_W-X_W){1'b0}}, x};
        mul_b = {2'b00, RECIP_5};
      end
    endcase
  end

  assign prod_low     = prod[ACC_W-1:0];
  assign speed_scaled = $signed({7'd0, speed, 13'd0}) + $signed({9'd0, speed, 11'd0});
  assign mag          = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
  assign x_raw        = mag[ACC_W-1:11];
  assign q            = prod[30:18];

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD: acc <= prod_low <<< 9;
      ACC_ADD:  acc <= acc + (prod_low <<< 4) + (prod_low <<< 2);
      default: ;
    endcase
    if (ctrl.num_load) begin
      num <= ctrl.num_right ? (speed_scaled + acc) : (speed_scaled - acc);
    end
    if (ctrl.abs_load) begin
      neg <= num[ACC_W-1];
      x   <= (x_raw > {4'd0, X_CLAMP}) ? X_CLAMP : x_raw[X_W-1:0];
    end
    if (ctrl.left_load) begin
      left <= sat_drive(q, neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= {1'b0, err, sat_drive(q, neg), left};
    end
  end

endmodule

// ----- hw/rtl/lfsp_checker.sv -----
// Port-level assertions for the line-follow steering PID core, bound to its top level.
// It imports lfsp_pkg.
module lfsp_checker
  import lfsp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output word valid right after reset.");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output word changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Core ready again right after accepting a word.");

  a_error_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[30:26]) >= -5'sd9) && ($signed(m_tdata[30:26]) <= 5'sd9))
    else $error("Line error field out of range.");

endmodule

bind line_follow_steering_pid_core lfsp_checker u_lfsp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for line_follow_steering_pid_core: sends sensor words, predicts
// each steering result and compares it with the master stream word by word.
// It depends on lfsp_pkg and the line_follow_steering_pid_core RTL.
module testbench
  import lfsp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic                     pad;
    logic signed [ERR_W-1:0]  line_error;
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;
  } steer_word_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;
  logic [MODE_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [GAIN_W-1:0]         ki_model;
  logic [GAIN_W-1:0]         kd_model;
  logic [LIMIT_W-1:0]        sum_cap;
  logic signed [ERR_W-1:0]   prev_err_model;
  logic signed [INTEG_W-1:0] err_sum;

  steer_word_t pending_steer[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_cycles = 0;

  line_follow_steering_pid_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic logic signed [ERR_W-1:0] line_offset(
    input logic [SENSOR_W-1:0] s,
    input logic [MODE_W-1:0] mode
  );
    logic curve;
    int r;
    curve = (mode == MODE_CURVE);
    // Bit n-1 is sensor n; a zero bit means that sensor sees the line.
    if (!s[3] && !s[4]) r = 0;
    else if (s[3] && !s[4]) r = -1;
    else if (!s[3] && s[4]) r = 1;
    else if (!s[4] && !s[5]) r = -2;
    else if (!s[2] && !s[3]) r = 2;
    else if (mode == MODE_SLOW) r = 0;
    else if (s[4] && !s[5]) r = -3;
    else if (!s[2] && s[3]) r = 3;
    else if (!s[5] && !s[6]) r = -4;
    else if (!s[1] && !s[2]) r = 4;
    else if (s[5] && !s[6]) r = curve ? -6 : -5;
    else if (!s[1] && s[2]) r = curve ? 6 : 5;
    else if (!s[6] && !s[7]) r = curve ? -7 : -6;
    else if (!s[0] && !s[1]) r = curve ? 7 : 6;
    else if (s[6] && !s[7]) r = curve ? -9 : -7;
    else if (!s[0] && s[1]) r = curve ? 9 : 7;
    else r = 0;
    return ERR_W'(r);
  endfunction

  function automatic logic signed [DRIVE_W-1:0] drive_clip(input longint num);
    longint q;
    q = num / 10240;
    if (q > 4095) q = 4095;
    if (q < -4096) q = -4096;
    return q[DRIVE_W-1:0];
  endfunction

  function automatic steer_word_t steer_predict(
    input logic [SENSOR_W-1:0] sensors,
    input logic [SPEED_W-1:0] speed,
    input logic [MODE_W-1:0] mode
  );
    steer_word_t w;
    logic signed [ERR_W-1:0] e;
    int s;
    int cap;
    longint sp;
    longint kp;
    longint d;
    longint change;
    sp = speed;
    change = 0;
    e = '0;
    if (mode == MODE_OFF) begin
      prev_err_model = '0;
      err_sum = '0;
    end else begin
      kp = (mode == MODE_CURVE) ? 5 : 3;
      e = line_offset(sensors, mode);
      cap = sum_cap;
      s = int'(err_sum) + int'(e);
      if (s >= cap) s = cap;
      if (s < -32768) s = -32768;
      err_sum = INTEG_W'(s);
      d = longint'(e) - longint'(prev_err_model);
      prev_err_model = e;
      change = kp * sp * longint'(e) * 512 + longint'(ki_model) * longint'(s) * 20
             + longint'(kd_model) * d * 20;
    end
    w.pad = 1'b0;
    w.line_error = e;
    w.left_drive = drive_clip(sp * 10240 - change);
    w.right_drive = drive_clip(sp * 10240 + change);
    return w;
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin
    steer_word_t got;
    steer_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_steer.size() == 0) begin
        report_mismatch("unexpected word, bits", 0, m_tdata);
      end else begin
        want = pending_steer.pop_front();
        if (got.left_drive !== want.left_drive)
          report_mismatch("left_drive", want.left_drive, got.left_drive);
        if (got.right_drive !== want.right_drive)
          report_mismatch("right_drive", want.right_drive, got.right_drive);
        if (got.line_error !== want.line_error)
          report_mismatch("line_error", want.line_error, got.line_error);
      end
    end
  end

  task automatic send_word(
    input logic [SENSOR_W-1:0] sensors,
    input logic [SPEED_W-1:0] speed,
    input logic [MODE_W-1:0] mode
  );
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, speed, sensors};
    s_tuser  <= mode;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_steer.push_back(steer_predict(sensors, speed, mode));
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_IGAIN:  ki_model = val[GAIN_W-1:0];
      REG_DGAIN:  kd_model = val[GAIN_W-1:0];
      REG_ILIMIT: sum_cap  = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(
    input logic [CFG_DATA_W-1:0] ki_word,
    input logic [CFG_DATA_W-1:0] kd_word,
    input logic [CFG_DATA_W-1:0] cap_word
  );
    settle();
    write_reg(REG_IGAIN, ki_word);
    write_reg(REG_DGAIN, kd_word);
    write_reg(REG_ILIMIT, cap_word);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SENSOR_W-1:0] pick_sensors();
    int r;
    int width;
    int pos;
    logic [SENSOR_W-1:0] mask;
    r = $urandom_range(99);
    if (r < 15) return SENSOR_W'($urandom);
    if (r < 20) return 8'hFF;
    width = $urandom_range(1, 3);
    pos = $urandom_range(0, SENSOR_W - width);
    mask = SENSOR_W'(((1 << width) - 1) << pos);
    return ~mask;
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return 10'd1023;
    if (r < 25) return 10'd1000;
    return SPEED_W'($urandom_range(1023));
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    if ($urandom_range(99) < 8) return MODE_OFF;
    return MODE_W'($urandom_range(1, 3));
  endfunction

  task automatic send_random();
    logic [SENSOR_W-1:0] sensors;
    logic [SPEED_W-1:0] speed;
    logic [MODE_W-1:0] mode;
    sensors = pick_sensors();
    speed = pick_speed();
    mode = pick_mode();
    send_word(sensors, speed, mode);
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_word(8'h00, 10'd1023, MODE_OFF);
    send_word(8'hFF, 10'd0, MODE_OFF);
    for (int i = 0; i < SENSOR_W; i++)
      send_word(~(8'd1 << i), i[0] ? 10'd1023 : 10'd517, MODE_QUICK);
    for (int i = 0; i < SENSOR_W; i++)
      send_word(~(8'd1 << i), 10'd1000, MODE_CURVE);
    send_word(8'hF7, 10'd600, MODE_SLOW);
    send_word(8'hEF, 10'd1023, MODE_SLOW);
    send_word(8'hFB, 10'd400, MODE_SLOW);
    send_word(8'hFF, 10'd0, MODE_SLOW);
    send_word(8'h00, 10'd1023, MODE_QUICK);
    send_word(8'hFF, 10'd1023, MODE_CURVE);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin src_idle_pct = 17; snk_idle_pct = 67; end
        1: begin src_idle_pct = 67; snk_idle_pct = 17; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (int c = 0; c < 2; c++) begin
        case (p * 2 + c)
          0: apply_config(15'h00FF, 15'h00FF, 15'd32767);
          1: apply_config(15'h7F00, 15'h7F00, 15'd0);
          2: apply_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom_range(60)));
          3: apply_config(15'h00FF, 15'h0000, 15'd5);
          4: apply_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom));
          default: apply_config(15'h0000, 15'h00FF, LIMIT_RESET);
        endcase
        repeat (55) send_random();
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    apply_config(CFG_DATA_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(255)),
                 LIMIT_RESET);
    @(posedge clk);
    hold_cycles = 300;
    repeat (10) send_random();
    settle();
    repeat (5) send_random();
  endtask

  task automatic test_integral_swing();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    apply_config(15'h00FF, 15'h00FF, LIMIT_RESET);
    send_word(8'hFF, 10'd500, MODE_OFF);
    // Sensor 8 alone in curve mode gives the largest left error, so a run of
    // it pulls the accumulated error well below zero.
    repeat (30) send_word(8'h7F, SPEED_W'($urandom_range(1023)), MODE_CURVE);
    repeat (4) send_word(8'hFE, 10'd1023, MODE_CURVE);
    apply_config(15'h00FF, 15'h00FF, 15'd0);
    repeat (6) send_word(8'hFE, SPEED_W'($urandom_range(1023)), MODE_QUICK);
    repeat (6) send_word(8'h7F, SPEED_W'($urandom_range(1023)), MODE_QUICK);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = MODE_OFF;
    cfg_we    = 1'b0;
    cfg_index = REG_IGAIN;
    cfg_data  = '0;
    ki_model  = '0;
    kd_model  = '0;
    sum_cap   = LIMIT_RESET;
    prev_err_model = '0;
    err_sum   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_phases();
    test_backpressure();
    test_integral_swing();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_steer.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lfsp_pkg.sv
hw/rtl/lfsp_mult.sv
hw/rtl/lfsp_ctrl.sv
hw/rtl/line_follow_steering_pid_core.sv
hw/rtl/lfsp_checker.sv
tb/testbench.sv
